### design/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types, register indexes and saturation and rounding helpers for the pointer delta
// conditioner.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam logic [2:0] REG_GRAB   = 3'd0;
  localparam logic [2:0] REG_GAIN   = 3'd1;
  localparam logic [2:0] REG_CAP    = 3'd2;
  localparam logic [2:0] REG_SMOOTH = 3'd3;
  localparam logic [2:0] REG_DECEL  = 3'd4;

  localparam logic signed [27:0] DMAX = 28'sd8388607;
  localparam logic signed [27:0] DMIN = -28'sd8388608;

  typedef logic signed [23:0] delta_t;
  typedef logic signed [57:0] prod_t;

  typedef struct packed {
    logic        grab;
    logic [23:0] gain;
    logic [22:0] cap;
    logic [23:0] smooth;
    logic [23:0] decel;
  } pdc_cfg_t;

  function automatic delta_t sat24(input logic signed [27:0] v);
    delta_t r;
    if (v > DMAX) begin
      r = DMAX[23:0];
    end else if (v < DMIN) begin
      r = DMIN[23:0];
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Shift right by 16, rounding half away from zero.
  function automatic logic signed [27:0] shr_round16(input prod_t p);
    logic [57:0] u;
    logic [57:0] q;
    logic signed [27:0] m;
    u = p[57] ? 58'(-p) : 58'(p);
    q = (u + 58'd32768) >> 16;
    m = $signed(q[27:0]);
    return p[57] ? -m : m;
  endfunction

endpackage

### design/pdc_mul.sv
// ----------------------------------------------------------------------------
// pdc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pdc_mul (
  input  logic                 clk,
  input  logic signed [31:0]   a,
  input  logic signed [25:0]   b,
  output pdc_pkg::prod_t       prod
);
  import pdc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= prod_t'(a) * prod_t'(b);
  end

endmodule

### design/pdc_core.sv
// ----------------------------------------------------------------------------
// pdc_core
// Sequencer for acceleration, capping and smoothing around one multiplier.
// ----------------------------------------------------------------------------
module pdc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [15:0]       rel_x,
  input  logic [15:0]       rel_y,
  input  logic [15:0]       frame_time,
  input  pdc_pkg::pdc_cfg_t cfg,
  input  logic              out_free,
  output logic              idle,
  output logic              done,
  output pdc_pkg::delta_t   res_dx,
  output pdc_pkg::delta_t   res_dy
);
  import pdc_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_AMUL1 = 5'd1;
  localparam logic [4:0] S_AMUL2 = 5'd2;
  localparam logic [4:0] S_AMUL3 = 5'd3;
  localparam logic [4:0] S_DIFF  = 5'd4;
  localparam logic [4:0] S_SQX   = 5'd5;
  localparam logic [4:0] S_SQY   = 5'd6;
  localparam logic [4:0] S_SQS   = 5'd7;
  localparam logic [4:0] S_RT    = 5'd8;
  localparam logic [4:0] S_RC    = 5'd9;
  localparam logic [4:0] S_LMUL  = 5'd10;
  localparam logic [4:0] S_LDIV  = 5'd11;
  localparam logic [4:0] S_LAMT  = 5'd12;
  localparam logic [4:0] S_T1    = 5'd13;
  localparam logic [4:0] S_T2    = 5'd14;
  localparam logic [4:0] S_APPX  = 5'd15;
  localparam logic [4:0] S_APPY  = 5'd16;
  localparam logic [4:0] S_APPE  = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;

  logic [4:0]         state;
  logic               ax;
  logic signed [15:0] rx;
  logic signed [15:0] ry;
  logic [15:0]        ft;
  delta_t             dx;
  delta_t             dy;
  delta_t             prev_dx;
  delta_t             prev_dy;
  logic signed [24:0] ddx;
  logic signed [24:0] ddy;
  logic [48:0]        sq;
  logic [11:0]        root;
  logic [3:0]         bitn;
  logic [16:0]        amt;

  logic signed [31:0] op_a;
  logic signed [25:0] op_b;
  prod_t              prod;

  logic signed [16:0] rsel;
  logic [16:0]        absr;
  logic [11:0]        trial;
  logic [15:0]        sm;
  logic [12:0]        dt;
  logic [24:0]        rate;
  logic               small_x;
  logic               small_y;
  logic               two_x;
  logic               two_y;
  logic [45:0]        mag;
  logic [45:0]        mag_c;
  logic [48:0]        sq_sum;
  logic [16:0]        qdiv;
  logic [21:0]        tamt;
  logic signed [24:0] avg_x;
  logic signed [24:0] avg_y;

  function automatic delta_t half_round(input logic signed [24:0] v);
    logic [24:0] u;
    logic [24:0] h;
    u = v[24] ? 25'(-v) : 25'(v);
    h = (u + 25'd1) >> 1;
    return v[24] ? -delta_t'(h[23:0]) : delta_t'(h[23:0]);
  endfunction

  pdc_mul u_mul (
    .clk  (clk),
    .a    (op_a),
    .b    (op_b),
    .prod (prod)
  );

  always_comb begin
    rsel    = ax ? {ry[15], ry} : {rx[15], rx};
    absr    = rsel[16] ? 17'(-rsel) : 17'(rsel);
    trial   = root | (12'd1 << bitn);
    sm      = (cfg.smooth < 24'd58982) ? cfg.smooth[15:0] : 16'd58982;
    dt      = (ft < 16'd6554) ? ft[12:0] : 13'd6554;
    small_x = (dx >= -24'sd2) && (dx <= 24'sd2);
    small_y = (dy >= -24'sd2) && (dy <= 24'sd2);
    two_x   = (dx == 24'sd2) || (dx == -24'sd2);
    two_y   = (dy == 24'sd2) || (dy == -24'sd2);
    if (small_x && small_y && !(two_x && two_y)) begin
      rate = (cfg.decel >= 24'd7) ? {1'b0, cfg.decel} : {cfg.smooth, 1'b0};
    end else begin
      rate = {1'b0, cfg.smooth};
    end
    mag     = 46'((prod[53:0] + 54'd128) >> 8);
    mag_c   = (mag > 46'd8388607) ? 46'd8388607 : mag;
    if (mag_c > {23'd0, cfg.cap}) begin
      mag_c = {23'd0, cfg.cap};
    end
    sq_sum  = sq + prod[48:0];
    qdiv    = prod[38:22];
    tamt    = prod[37:16];
    avg_x   = 25'(dx) + 25'(prev_dx);
    avg_y   = 25'(dy) + 25'(prev_dy);
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_AMUL1: begin
        op_a = {15'd0, absr};
        op_b = {9'd0, absr};
      end
      S_AMUL2: begin
        op_a = {1'd0, prod[30:0]};
        op_b = {2'd0, cfg.gain};
      end
      S_SQX, S_APPX: begin
        op_a = 32'(ddx);
        op_b = (state == S_SQX) ? 26'(ddx) : {9'd0, amt};
      end
      S_SQY, S_APPY: begin
        op_a = 32'(ddy);
        op_b = (state == S_SQY) ? 26'(ddy) : {9'd0, amt};
      end
      S_RT: begin
        op_a = {20'd0, trial};
        op_b = {14'd0, trial};
      end
      S_LMUL: begin
        op_a = {20'd0, root};
        op_b = {10'd0, sm};
      end
      S_LDIV: begin
        op_a = {13'd0, prod[27:9]};
        op_b = 26'd838861;
      end
      S_T1: begin
        op_a = {7'd0, rate};
        op_b = {13'd0, dt};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign idle   = (state == S_IDLE);
  assign done   = (state == S_FIN) && out_free;
  assign res_dx = dx;
  assign res_dy = dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      prev_dx <= '0;
      prev_dy <= '0;
      ax      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rx <= $signed(rel_x);
            ry <= $signed(rel_y);
            ft <= frame_time;
            ax <= 1'b0;
            dx <= delta_t'({rel_x, 8'd0});
            dy <= delta_t'({rel_y, 8'd0});
            if (cfg.grab && (rel_x != 16'd0 || rel_y != 16'd0)) begin
              state <= (cfg.gain != 24'd0) ? S_AMUL1 : S_DIFF;
            end
          end
        end
        S_AMUL1: state <= S_AMUL2;
        S_AMUL2: state <= S_AMUL3;
        S_AMUL3: begin
          if (ax) begin
            dy    <= rsel[16] ? -delta_t'(mag_c[23:0]) : delta_t'(mag_c[23:0]);
            state <= S_DIFF;
          end else begin
            dx    <= rsel[16] ? -delta_t'(mag_c[23:0]) : delta_t'(mag_c[23:0]);
            ax    <= 1'b1;
            state <= S_AMUL1;
          end
        end
        S_DIFF: begin
          ddx <= 25'(dx) - 25'(prev_dx);
          ddy <= 25'(dy) - 25'(prev_dy);
          priority if (cfg.smooth < 24'd7) begin
            state <= S_FIN;
          end else if (cfg.smooth < 24'd65530) begin
            state <= S_SQX;
          end else if (cfg.smooth < 24'd65543) begin
            dx      <= half_round(avg_x);
            dy      <= half_round(avg_y);
            prev_dx <= half_round(avg_x);
            prev_dy <= half_round(avg_y);
            state   <= S_FIN;
          end else begin
            state <= S_T1;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          sq    <= prod[48:0];
          state <= S_SQS;
        end
        S_SQS: begin
          sq   <= sq_sum;
          bitn <= 4'd11;
          if (sq_sum >= 49'd6553600) begin
            root  <= 12'd2560;
            state <= S_LMUL;
          end else begin
            root  <= 12'd0;
            state <= S_RT;
          end
        end
        S_RT: state <= S_RC;
        S_RC: begin
          if (prod[48:0] <= sq) begin
            root <= trial;
          end
          if (bitn == 4'd0) begin
            state <= S_LMUL;
          end else begin
            bitn  <= bitn - 4'd1;
            state <= S_RT;
          end
        end
        S_LMUL: state <= S_LDIV;
        S_LDIV: state <= S_LAMT;
        S_LAMT: begin
          amt   <= 17'd65536 - qdiv;
          state <= S_APPX;
        end
        S_T1: state <= S_T2;
        S_T2: begin
          amt   <= (tamt > 22'd65536) ? 17'd65536 : tamt[16:0];
          state <= S_APPX;
        end
        S_APPX: state <= S_APPY;
        S_APPY: begin
          dx    <= sat24(28'(prev_dx) + shr_round16(prod));
          state <= S_APPE;
        end
        S_APPE: begin
          dy      <= sat24(28'(prev_dy) + shr_round16(prod));
          prev_dx <= dx;
          prev_dy <= sat24(28'(prev_dy) + shr_round16(prod));
          state   <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/pointer_delta_conditioner_unit.sv
// ----------------------------------------------------------------------------
// pointer_delta_conditioner_unit
// Relative pointer motion conditioner: acceleration, capping and smoothing.
// ----------------------------------------------------------------------------
// Raw motion enters on the s_ group, one transaction per report. Conditioned
// deltas leave on the m_ group. Registers are written over the cfg_ channel,
// which is always ready; they should only change while the block is idle.
// A report is dropped, with no output, when grab is off or rel_x and rel_y
// are both zero. Otherwise exactly one output transaction follows.
// A report takes its shortest path to output valid with no acceleration and
// pass-through, its longest with acceleration and the length-weighted blend;
// the 12-step square root, each step a trial square through the shared
// multiplier and a compare, dominates the latter. s_tready is low while a
// report is being worked on, so a new report is taken only once the
// sequencer has finished with the previous one. The result sits in an
// output register; while the receiver stalls the next report can still be
// taken, but its result waits in the sequencer until the register empties.
// Synchronous reset clears the configuration, previous delta and output valid.
// ----------------------------------------------------------------------------
module pointer_delta_conditioner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // rel_x, rel_y, frame_time
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_dx, out_dy
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import pdc_pkg::*;

  pdc_cfg_t cfg;
  logic     out_free;
  logic     core_idle;
  logic     core_done;
  delta_t   res_dx;
  delta_t   res_dy;

  assign cfg_ready = 1'b1;
  assign s_tready  = core_idle;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRAB:   cfg.grab   <= cfg_data[0];
        REG_GAIN:   cfg.gain   <= cfg_data;
        REG_CAP:    cfg.cap    <= cfg_data[22:0];
        REG_SMOOTH: cfg.smooth <= cfg_data;
        REG_DECEL:  cfg.decel  <= cfg_data;
        default:    cfg        <= cfg;
      endcase
    end
  end

  pdc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (s_tvalid && s_tready),
    .rel_x      (s_tdata[15:0]),
    .rel_y      (s_tdata[31:16]),
    .frame_time (s_tdata[47:32]),
    .cfg        (cfg),
    .out_free   (out_free),
    .idle       (core_idle),
    .done       (core_done),
    .res_dx     (res_dx),
    .res_dy     (res_dy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (core_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      m_tdata <= {res_dy, res_dx};
    end
  end

endmodule

### design/pdc_checker.sv
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks for the pointer delta conditioner.
// ----------------------------------------------------------------------------
module pdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        cfg_ready
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output changed");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared one cycle after input");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind pointer_delta_conditioner_unit pdc_checker u_pdc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);

### bench/pointer_delta_conditioner_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pointer_delta_conditioner_unit_tb
// Self-checking bench for the pointer delta conditioner. Motion reports are
// driven on the input stream with random gaps, and each report's conditioned
// delta is predicted and queued. Output transactions are compared in order
// against that queue while the receiver stalls at random. The run walks
// through several register settings, written only while the block is idle.
// ----------------------------------------------------------------------------
module pointer_delta_conditioner_unit_tb;
  import pdc_pkg::*;

  typedef struct packed {
    logic [15:0] ft;
    logic [15:0] ry;
    logic [15:0] rx;
  } report_t;

  typedef struct {
    logic signed [23:0] dx;
    logic signed [23:0] dy;
  } delta_pair_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  pointer_delta_conditioner_unit dut (.*);

  report_t     pending_reports[$];
  delta_pair_t expected_deltas[$];

  logic        m_grab;
  logic [23:0] m_gain;
  logic [22:0] m_cap;
  logic [23:0] m_smooth;
  logic [23:0] m_decel;
  longint      m_prev_dx;
  longint      m_prev_dy;

  int  mismatches = 0;
  int  failures = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_off = 0;
  bit  sender_busy = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint round_shift(longint v, int sh);
    longint u;
    u = (v < 0) ? -v : v;
    u = (u + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -u : u;
  endfunction

  function automatic longint accelerated_axis(longint r);
    longint a;
    longint m;
    a = (r < 0) ? -r : r;
    m = (a * a * longint'(m_gain) + 128) >>> 8;
    if (m > 8388607) m = 8388607;
    if (m > longint'(m_cap)) m = m_cap;
    return (r < 0) ? -m : m;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // Returns 1 and fills the pair when the report produces a delta.
  function automatic bit condition_report(report_t rp, output delta_pair_t res);
    longint rx, ry, ft, dx, dy, ddx, ddy, s, sq, len, sm, amt, dt, rate;
    rx = longint'($signed(rp.rx));
    ry = longint'($signed(rp.ry));
    ft = rp.ft;
    s  = m_smooth;
    res.dx = '0;
    res.dy = '0;
    if (!m_grab || (rx == 0 && ry == 0)) return 0;
    if (m_gain != 0) begin
      dx = accelerated_axis(rx);
      dy = accelerated_axis(ry);
    end else begin
      dx = rx * 256;
      dy = ry * 256;
    end
    ddx = dx - m_prev_dx;
    ddy = dy - m_prev_dy;
    if (s >= 7) begin
      if (s < 65530) begin
        sq  = ddx * ddx + ddy * ddy;
        len = (sq >= 2560 * 2560) ? 2560 : floor_sqrt(sq);
        sm  = (s < 58982) ? s : 58982;
        amt = 65536 - (len * sm) / 2560;
        dx  = clamp24(m_prev_dx + round_shift(ddx * amt, 16));
        dy  = clamp24(m_prev_dy + round_shift(ddy * amt, 16));
      end else if (s < 65543) begin
        dx = clamp24(round_shift(dx + m_prev_dx, 1));
        dy = clamp24(round_shift(dy + m_prev_dy, 1));
      end else begin
        dt = (ft < 6554) ? ft : 6554;
        if (dx * dx + dy * dy < 7)
          rate = (m_decel >= 7) ? longint'(m_decel) : 2 * s;
        else
          rate = s;
        amt = (dt * rate) >>> 16;
        if (amt > 65536) amt = 65536;
        dx = clamp24(m_prev_dx + round_shift(ddx * amt, 16));
        dy = clamp24(m_prev_dy + round_shift(ddy * amt, 16));
      end
      m_prev_dx = dx;
      m_prev_dy = dy;
    end
    res.dx = dx[23:0];
    res.dy = dy[23:0];
    return 1;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sender: offers queued reports with random gaps and predicts on acceptance.
  always @(posedge clk) begin
    delta_pair_t res;
    report_t     rp;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        rp = s_tdata;
        if (condition_report(rp, res)) expected_deltas.push_back(res);
        void'(pending_reports.pop_front());
      end
      if (s_tvalid && !s_tready) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if ((s_tvalid && s_tready ? pending_reports.size() : pending_reports.size())
                   != 0 && !(s_tvalid && s_tready && pending_reports.size() == 0)) begin
        if (s_tvalid && s_tready && $urandom_range(0, 3) == 0) begin
          send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                  : $urandom_range(0, 3);
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_reports[0];
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    delta_pair_t want;
    logic signed [23:0] got_dx, got_dy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_dx = m_tdata[23:0];
        got_dy = m_tdata[47:24];
        if (expected_deltas.size() == 0) begin
          failures++;
          if (mismatches < 10)
            $display("unexpected output dx=%0d dy=%0d", got_dx, got_dy);
          mismatches++;
        end else begin
          want = expected_deltas.pop_front();
          if (want.dx !== got_dx || want.dy !== got_dy) begin
            failures++;
            if (mismatches < 10)
              $display("mismatch: expected dx=%0d dy=%0d, got dx=%0d dy=%0d",
                       want.dx, want.dy, got_dx, got_dy);
            mismatches++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(1, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (pending_reports.size() != 0 || s_tvalid || expected_deltas.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRAB:   m_grab   = val[0];
      REG_GAIN:   m_gain   = val;
      REG_CAP:    m_cap    = val[22:0];
      REG_SMOOTH: m_smooth = val;
      REG_DECEL:  m_decel  = val;
      default: ;
    endcase
  endtask

  task automatic queue_report(int rx, int ry, int ft);
    report_t rp;
    rp.rx = rx[15:0];
    rp.ry = ry[15:0];
    rp.ft = ft[15:0];
    pending_reports.push_back(rp);
  endtask

  function automatic int rand_motion();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65535) - 32768;
      1: return 0;
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return $urandom_range(0, 40) - 20;
    endcase
  endfunction

  task automatic queue_random(int n);
    int rx;
    for (int i = 0; i < n; i++) begin
      rx = rand_motion();
      queue_report(rx, rand_motion(), $urandom_range(0, 65535));
    end
  endtask

  initial begin
    logic [23:0] smooth_set[6];
    logic [23:0] gain_set[4];
    logic [23:0] cap_set[4];
    logic [23:0] decel_set[3];
    smooth_set = '{24'd0, 24'd6, 24'd30000, 24'd65535, 24'd200000, 24'hFFFFFF};
    gain_set   = '{24'd0, 24'd65536, 24'd3, 24'hFFFFFF};
    cap_set    = '{24'd0, 24'd5000, 24'h7FFFFF, 24'd100};
    decel_set  = '{24'd0, 24'd3, 24'hFFFFFF};
    m_grab = 0; m_gain = 0; m_cap = 0; m_smooth = 0; m_decel = 0;
    m_prev_dx = 0; m_prev_dy = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Grab off: nothing should come out.
    queue_report(5, 5, 100);
    wait_idle();
    write_reg(REG_GRAB, 24'd1);
    write_reg(3'd7, 24'd0);
    queue_report(0, 0, 0);
    queue_report(32767, -32768, 65535);
    queue_report(-32768, 32767, 0);
    queue_report(1, -1, 1);
    queue_report(-1, 0, 6554);
    wait_idle();
    write_reg(REG_GAIN, 24'hFFFFFF);
    write_reg(REG_CAP, 24'd0);
    queue_report(300, -300, 10);
    queue_report(32767, -32768, 65535);
    wait_idle();
    write_reg(REG_GAIN, 24'd1);
    write_reg(REG_CAP, 24'h7FFFFF);
    queue_report(1, 1, 100);
    queue_report(-7, 3, 100);
    wait_idle();
    write_reg(REG_SMOOTH, 24'd200000);
    write_reg(REG_DECEL, 24'd0);
    queue_report(1, 0, 6000);
    queue_report(1, 0, 65535);
    wait_idle();
    write_reg(REG_DECEL, 24'd0);
    queue_report(-3, 2, 6554);
    wait_idle();
    write_reg(REG_DECEL, 24'd70000);
    queue_report(1, -1, 3000);
    wait_idle();

    // Long receiver hold-off while reports keep coming.
    hold_off = 400;
    queue_random(10);
    wait_idle();

    for (int ph = 0; ph < 24; ph++) begin
      write_reg(REG_SMOOTH, ($urandom_range(0, 3) == 0)
                            ? 24'($urandom_range(0, 24'hFFFFFF)) : smooth_set[ph % 6]);
      write_reg(REG_GAIN, (ph % 5 == 4) ? 24'($urandom_range(0, 24'hFFFFFF))
                                        : gain_set[(ph / 6) % 4]);
      write_reg(REG_CAP, (ph % 7 == 3) ? 24'($urandom_range(0, 24'h7FFFFF))
                                       : cap_set[ph % 4]);
      write_reg(REG_DECEL, (ph % 4 == 1) ? 24'($urandom_range(0, 24'hFFFFFF))
                                         : decel_set[ph % 3]);
      write_reg(REG_GRAB, (ph % 8 == 7) ? 24'd0 : 24'd1);
      queue_random(40);
      wait_idle();
    end

    if (failures == 0 && expected_deltas.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
